[rtl/core/logical_shifted_register_alu_unit_assert.svh]
// Assertion macros shared by the logical shifted-register ALU RTL
`ifndef LOGICAL_SHIFTED_REGISTER_ALU_UNIT_ASSERT_SVH
`define LOGICAL_SHIFTED_REGISTER_ALU_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define LSRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsra assertion failed");

// next-cycle implication, off while in reset
`define LSRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsra assertion failed");

`endif

[rtl/core/lsra_pkg.sv]
// Types and constants for the logical shifted-register ALU
`default_nettype none
package lsra_pkg;

    localparam int unsigned XLEN      = 64;
    localparam int unsigned INSN_W    = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam int unsigned AMT_W     = 6;
    localparam int unsigned IN_DATA_W  = 160;
    localparam int unsigned OUT_DATA_W = 80;

    localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd31;

    typedef enum logic [1:0] {
        SHIFT_LSL = 2'b00,
        SHIFT_LSR = 2'b01,
        SHIFT_ASR = 2'b10,
        SHIFT_ROR = 2'b11
    } shift_t;

    typedef enum logic [1:0] {
        OPC_AND  = 2'b00,
        OPC_ORR  = 2'b01,
        OPC_EOR  = 2'b10,
        OPC_ANDS = 2'b11
    } opc_t;

    typedef struct packed {
        logic [XLEN-1:0]   second_operand;
        logic [XLEN-1:0]   first_operand;
        logic [INSN_W-1:0] instruction_word;
    } in_word_t;

    typedef struct packed {
        logic                 reserved_encoding;
        logic                 flag_overflow;
        logic                 flag_carry;
        logic                 flag_zero;
        logic                 flag_negative;
        logic                 flags_update;
        logic                 write_enable;
        logic [XLEN-1:0]      result_value;
        logic [REG_IDX_W-1:0] dest_index;
    } result_t;

endpackage
`default_nettype wire

[rtl/core/lsra_shift.sv]
// Barrel shifter for the second operand: LSL, LSR, ASR, ROR at 32 or 64 bits
`default_nettype none
module lsra_shift (
    input  wire logic [lsra_pkg::XLEN-1:0]  operand,
    input  wire lsra_pkg::shift_t           shift_type,
    input  wire logic [lsra_pkg::AMT_W-1:0] amount,
    input  wire logic                       wide,
    output logic [lsra_pkg::XLEN-1:0]       shifted
);
    import lsra_pkg::*;

    logic [AMT_W-1:0]  amt;
    logic [XLEN-1:0]   mask;
    logic [XLEN-1:0]   v;
    logic [XLEN-1:0]   vs;
    logic [XLEN-1:0]   r;
    logic [2*XLEN-1:0] dbl;
    logic [XLEN-1:0]   dbl32;

    always_comb
    begin
        amt   = wide ? amount : {1'b0, amount[AMT_W-2:0]};
        mask  = wide ? {XLEN{1'b1}} : {{(XLEN/2){1'b0}}, {(XLEN/2){1'b1}}};
        v     = operand & mask;
        // sign-extend the narrow form so an arithmetic shift fills correctly
        vs    = wide ? v : {{(XLEN/2){v[XLEN/2-1]}}, v[XLEN/2-1:0]};
        dbl   = {v, v} >> amt;
        dbl32 = {v[XLEN/2-1:0], v[XLEN/2-1:0]} >> amt[AMT_W-2:0];
        unique case (shift_type)
            SHIFT_LSL: r = v << amt;
            SHIFT_LSR: r = v >> amt;
            SHIFT_ASR: r = XLEN'($signed(vs) >>> amt);
            SHIFT_ROR: r = wide ? dbl[XLEN-1:0] : {{(XLEN/2){1'b0}}, dbl32[XLEN/2-1:0]};
            default:   r = v;
        endcase
        shifted = r & mask;
    end

endmodule
`default_nettype wire

[rtl/core/lsra_exec.sv]
// Decode, operand select, logical op and flag generation for one instruction
`default_nettype none
module lsra_exec (
    input  wire lsra_pkg::in_word_t in_word,
    output lsra_pkg::result_t       result
);
    import lsra_pkg::*;

    logic [INSN_W-1:0]    insn;
    logic                 wide;
    opc_t                 opc;
    shift_t               stype;
    logic                 invert;
    logic [REG_IDX_W-1:0] rm;
    logic [REG_IDX_W-1:0] rn;
    logic [REG_IDX_W-1:0] rd;
    logic [AMT_W-1:0]     imm6;
    logic [XLEN-1:0]      mask;
    logic [XLEN-1:0]      a;
    logic [XLEN-1:0]      b;
    logic [XLEN-1:0]      b_sh;
    logic [XLEN-1:0]      b_op;
    logic [XLEN-1:0]      res;
    logic                 reserved;
    logic                 setflags;

    assign insn   = in_word.instruction_word;
    assign wide   = insn[31];
    assign opc    = opc_t'(insn[30:29]);
    assign stype  = shift_t'(insn[23:22]);
    assign invert = insn[21];
    assign rm     = insn[20:16];
    assign imm6   = insn[15:10];
    assign rn     = insn[9:5];
    assign rd     = insn[4:0];
    assign mask   = wide ? {XLEN{1'b1}} : {{(XLEN/2){1'b0}}, {(XLEN/2){1'b1}}};
    assign reserved = !wide && imm6[AMT_W-1];

    assign a = (rn == REG_ZERO) ? '0 : (in_word.first_operand & mask);
    assign b = (rm == REG_ZERO) ? '0 : (in_word.second_operand & mask);

    lsra_shift u_shift (
        .operand    (b),
        .shift_type (stype),
        .amount     (imm6),
        .wide       (wide),
        .shifted    (b_sh)
    );

    assign b_op = invert ? (~b_sh & mask) : b_sh;

    always_comb
    begin
        setflags = 1'b0;
        unique case (opc)
            OPC_AND:  res = a & b_op;
            OPC_ORR:  res = a | b_op;
            OPC_EOR:  res = a ^ b_op;
            OPC_ANDS:
            begin
                res      = a & b_op;
                setflags = 1'b1;
            end
            default:  res = a & b_op;
        endcase

        result.dest_index        = rd;
        result.result_value      = reserved ? '0 : (res & mask);
        result.write_enable      = !reserved && (rd != REG_ZERO);
        result.flags_update      = !reserved && setflags;
        result.flag_negative     = !reserved && setflags && (wide ? res[XLEN-1] : res[XLEN/2-1]);
        result.flag_zero         = !reserved && setflags && ((res & mask) == '0);
        result.flag_carry        = 1'b0;
        result.flag_overflow     = 1'b0;
        result.reserved_encoding = reserved;
    end

endmodule
`default_nettype wire

[rtl/core/logical_shifted_register_alu_unit.sv]
// Top level: input register, logical execute logic, result register
//
//  channel  dir  tdata fields (low bit up)                                  tlast/tuser
//  s_*      in   instruction_word[31:0] first_operand[95:32] second_operand[159:96]   none
//  m_*      out  dest_index[4:0] result_value[68:5] write_enable[69] flags_update[70]
//                flag_negative[71] flag_zero[72] flag_carry[73] flag_overflow[74]
//                reserved_encoding[75] zero[79:76]                             none
//
//  One word per cycle unless a stall on m_tready holds the pipe; the input word passes
//  through the input register and then the result register before m_tvalid rises.
//  These two registers sit around one pass of shift, logical op and flag logic.
//  Reset clears both valid stages; payload registers are not reset.
//  A stall on m_tready holds the result register and backs up into the input register.
`default_nettype none
module logical_shifted_register_alu_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // instruction_word, first_operand, second_operand
    input  wire logic [lsra_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // dest_index, result_value, write_enable, flags_update, flag_negative,
    // flag_zero, flag_carry, flag_overflow, reserved_encoding, zero pad
    output logic [lsra_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import lsra_pkg::*;

    `include "logical_shifted_register_alu_unit_assert.svh"

    logic     in_valid_reg;
    logic     in_valid_next;
    in_word_t in_word_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_res_reg;
    result_t  exec_res;
    logic     st2_ready;
    logic     in_take;

    assign st2_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || st2_ready;
    assign in_take   = s_tvalid && s_tready;

    lsra_exec u_exec (
        .in_word (in_word_reg),
        .result  (exec_res)
    );

    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !st2_ready);
        out_valid_next = (in_valid_reg && st2_ready) || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_word_t'(s_tdata);
        end
        if (in_valid_reg && st2_ready)
        begin
            out_res_reg <= exec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res_reg};

    // a stalled input word must not be dropped
    `LSRA_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !st2_ready, in_valid_reg)
    // reserved forms write nothing and report nothing
    `LSRA_ASSERT_NOW(a_reserved_quiet, clk, rst_n,
        out_valid_reg && out_res_reg.reserved_encoding,
        !out_res_reg.write_enable && !out_res_reg.flags_update && out_res_reg.result_value == '0)
    // zero flag only with a zero result and a flag-setting form
    `LSRA_ASSERT_NOW(a_zero_flag, clk, rst_n, out_valid_reg && out_res_reg.flag_zero,
        out_res_reg.flags_update && out_res_reg.result_value == '0)
    // C and V are never set by logical ops
    `LSRA_ASSERT_NOW(a_cv_clear, clk, rst_n, out_valid_reg,
        !out_res_reg.flag_carry && !out_res_reg.flag_overflow)

endmodule
`default_nettype wire
